// File: hw/rtl/segment_box_intersect_defines.svh
// Assertion macros used by the segment-box intersection RTL.
`ifndef SEGMENT_BOX_INTERSECT_DEFINES_SVH
`define SEGMENT_BOX_INTERSECT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SBI_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("segment_box_intersect: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SBI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("segment_box_intersect: next-cycle check failed");

`endif

// File: hw/rtl/sbi_pkg.sv
// Package with widths, types and the range test of the segment-box intersection.
package sbi_pkg;

    // Coordinate width of every input field.
    localparam int CW    = 16;
    // Placed box corners, edge lengths and point offsets.
    localparam int OW    = CW + 3;
    // Segment direction components.
    localparam int SW    = CW + 1;
    // One cross-product term.
    localparam int PP    = OW + SW;
    // Difference of two cross-product terms.
    localparam int PW    = PP + 1;
    // Stream data widths, padded to whole bytes.
    localparam int IN_W  = ((12 * CW + 7) / 8) * 8;
    localparam int OUT_W = 8;

    // One input item, unpacked.
    typedef struct packed {
        logic signed [CW-1:0] seg_ax;
        logic signed [CW-1:0] seg_ay;
        logic signed [CW-1:0] seg_bx;
        logic signed [CW-1:0] seg_by;
        logic signed [CW-1:0] pos_x;
        logic signed [CW-1:0] pos_y;
        logic signed [CW-1:0] org_x;
        logic signed [CW-1:0] org_y;
        logic signed [CW-1:0] box_left;
        logic signed [CW-1:0] box_top;
        logic signed [CW-1:0] box_right;
        logic signed [CW-1:0] box_bottom;
    } t_coords;

    // Differences that feed the cross products.
    typedef struct packed {
        logic signed [SW-1:0] sgx;
        logic signed [SW-1:0] sgy;
        logic signed [OW-1:0] ox0;
        logic signed [OW-1:0] ox1;
        logic signed [OW-1:0] oy0;
        logic signed [OW-1:0] oy1;
        logic signed [OW-1:0] ex;
        logic signed [OW-1:0] ey;
    } t_geom;

    // True when n/d lies in [0,1], endpoints included; d is known to be nonzero.
    function automatic logic in_unit(input logic signed [PW-1:0] n,
                                     input logic signed [PW-1:0] d);
        logic r;
        if (d > 0) begin
            r = (n >= 0) && (n <= d);
        end else begin
            r = (n <= 0) && (n >= d);
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/segment_box_intersect.sv
// Segment versus axis-aligned box intersection test: input register, one pass, result register.
//
// Each item carries one line segment and one object box; the block answers with
// one bit that is set when the segment touches any of the four box edges, with
// both segment parameters in [0,1] and parallel edges never counting as a hit.
// The block takes one item every cycle while the output is not stalled; each item is held
// in the input register, then its result in the result register. All the work sits
// in the logic between the input register and the result register: the box
// placement and offset differences, the six cross-product multipliers, and the
// exact range compares. The input register loads whenever it is empty or the
// result register is empty or being taken, so one more item is accepted while a
// result waits, and the input is refused only when both registers are full and
// the output is stalled.
`include "segment_box_intersect_defines.svh"

module segment_box_intersect
    import sbi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // From bit 0 up: seg_ax, seg_ay, seg_bx, seg_by, pos_x, pos_y, org_x, org_y,
    // box_left, box_top, box_right, box_bottom.
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // From bit 0 up: hit, then zero padding.
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    // Register valids and enables.
    logic    r_in_valid;
    logic    r_out_valid;
    logic    en_in;
    logic    en_out;

    // Input register and the differences formed from it.
    t_coords r_in;
    t_geom   geom;

    logic signed [PP-1:0] p_xo0;
    logic signed [PP-1:0] p_xo1;
    logic signed [PP-1:0] p_yx0;
    logic signed [PP-1:0] p_yx1;
    logic signed [PP-1:0] p_dv;
    logic signed [PP-1:0] p_dh;
    logic                 f_left;
    logic                 f_right;
    logic                 f_top;
    logic                 f_bottom;

    logic signed [PW-1:0] m_left;
    logic signed [PW-1:0] m_right;
    logic signed [PW-1:0] m_bottom;
    logic signed [PW-1:0] d_vert;
    logic signed [PW-1:0] d_horz;
    logic                 n_hit;
    logic                 r_hit;

    // A register loads when the one after it is empty or handing its item on.
    assign en_out          = !r_out_valid || i_m_axis_tready;
    assign en_in           = !r_in_valid || en_out;
    assign o_s_axis_tready = en_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en_in) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (en_out) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Input register: unpack the stream word into coordinates.
    always_ff @(posedge i_clk) begin
        if (en_in) begin
            r_in.seg_ax     <= i_s_axis_tdata[0*CW +: CW];
            r_in.seg_ay     <= i_s_axis_tdata[1*CW +: CW];
            r_in.seg_bx     <= i_s_axis_tdata[2*CW +: CW];
            r_in.seg_by     <= i_s_axis_tdata[3*CW +: CW];
            r_in.pos_x      <= i_s_axis_tdata[4*CW +: CW];
            r_in.pos_y      <= i_s_axis_tdata[5*CW +: CW];
            r_in.org_x      <= i_s_axis_tdata[6*CW +: CW];
            r_in.org_y      <= i_s_axis_tdata[7*CW +: CW];
            r_in.box_left   <= i_s_axis_tdata[8*CW +: CW];
            r_in.box_top    <= i_s_axis_tdata[9*CW +: CW];
            r_in.box_right  <= i_s_axis_tdata[10*CW +: CW];
            r_in.box_bottom <= i_s_axis_tdata[11*CW +: CW];
        end
    end

    // Box placement and differences.
    sbi_place u_place (
        .i_c (r_in),
        .o_g (geom)
    );

    // Cross-product terms, plus the first-parameter tests, which reduce to
    // comparisons on the offsets since the edge length cancels in the ratio.
    assign p_xo0    = PP'(geom.sgx) * PP'(geom.oy0);
    assign p_xo1    = PP'(geom.sgx) * PP'(geom.oy1);
    assign p_yx0    = PP'(geom.sgy) * PP'(geom.ox0);
    assign p_yx1    = PP'(geom.sgy) * PP'(geom.ox1);
    assign p_dv     = PP'(geom.ey) * PP'(geom.sgx);
    assign p_dh     = PP'(geom.ex) * PP'(geom.sgy);
    assign f_left   = (geom.sgx != '0) && (geom.ey != '0) &&
                      in_unit(-PW'(geom.ox0), PW'(geom.sgx));
    assign f_right  = (geom.sgx != '0) && (geom.ey != '0) &&
                      in_unit(-PW'(geom.ox1), PW'(geom.sgx));
    assign f_top    = (geom.sgy != '0) && (geom.ex != '0) &&
                      in_unit(-PW'(geom.oy0), PW'(geom.sgy));
    assign f_bottom = (geom.sgy != '0) && (geom.ex != '0) &&
                      in_unit(-PW'(geom.oy1), PW'(geom.sgy));

    // Second-parameter numerators and denominators. The top edge shares its
    // start corner with the left edge, so both use the same numerator.
    assign m_left   = PW'(p_xo0) - PW'(p_yx0);
    assign m_right  = PW'(p_xo0) - PW'(p_yx1);
    assign m_bottom = PW'(p_xo1) - PW'(p_yx0);
    assign d_vert   = PW'(p_dv);
    assign d_horz   = -PW'(p_dh);

    assign n_hit = (f_left   && in_unit(m_left,   d_vert)) ||
                   (f_right  && in_unit(m_right,  d_vert)) ||
                   (f_top    && in_unit(m_left,   d_horz)) ||
                   (f_bottom && in_unit(m_bottom, d_horz));

    // Result register.
    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_hit <= n_hit;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_W-1){1'b0}}, r_hit};

    // An empty input register always takes an item.
    `SBI_ASSERT_SAME(a_ready_when_empty, !r_in_valid, o_s_axis_tready)
    // An accepted item is held in the input register on the next cycle.
    `SBI_ASSERT_NEXT(a_accept_lands, i_s_axis_tvalid && o_s_axis_tready, r_in_valid)
    // With the output stalled, an item in the input register is kept, not dropped.
    `SBI_ASSERT_NEXT(a_stall_keeps_in, r_in_valid && r_out_valid && !i_m_axis_tready, r_in_valid)

endmodule

// File: hw/rtl/sbi_place.sv
// Places the box and forms the segment and offset differences for the edge tests.
module sbi_place
    import sbi_pkg::*;
(
    input  t_coords i_c,
    output t_geom   o_g
);

    logic signed [OW-1:0] x0;
    logic signed [OW-1:0] y0;
    logic signed [OW-1:0] x1;
    logic signed [OW-1:0] y1;

    // Box corners: position minus origin plus the relative edge.
    assign x0 = OW'(i_c.pos_x) - OW'(i_c.org_x) + OW'(i_c.box_left);
    assign y0 = OW'(i_c.pos_y) - OW'(i_c.org_y) + OW'(i_c.box_top);
    assign x1 = OW'(i_c.pos_x) - OW'(i_c.org_x) + OW'(i_c.box_right);
    assign y1 = OW'(i_c.pos_y) - OW'(i_c.org_y) + OW'(i_c.box_bottom);

    // Segment direction, start point offsets to the corners, and edge lengths.
    always_comb begin
        o_g.sgx = SW'(i_c.seg_bx) - SW'(i_c.seg_ax);
        o_g.sgy = SW'(i_c.seg_by) - SW'(i_c.seg_ay);
        o_g.ox0 = OW'(i_c.seg_ax) - x0;
        o_g.ox1 = OW'(i_c.seg_ax) - x1;
        o_g.oy0 = OW'(i_c.seg_ay) - y0;
        o_g.oy1 = OW'(i_c.seg_ay) - y1;
        o_g.ex  = x1 - x0;
        o_g.ey  = y1 - y0;
    end

endmodule

// File: tb/segment_box_intersect_checker.sv
// Checker that predicts the hit bit of every accepted query and compares it with the output.
module segment_box_intersect_checker
    import sbi_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_tready,
    // From bit 0 up: seg_ax, seg_ay, seg_bx, seg_by, pos_x, pos_y, org_x, org_y,
    // box_left, box_top, box_right, box_bottom.
    input  logic [IN_W-1:0]  i_s_tdata,
    input  logic             i_m_tvalid,
    input  logic             i_m_tready,
    // From bit 0 up: hit, then zero padding.
    input  logic [OUT_W-1:0] i_m_tdata,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked,
    output int               o_hits
);

    // Predicted hit bits, oldest first.
    bit hit_expected_q[$];

    // True when n/d lies in [0,1], both ends included.
    function automatic bit param_in_unit(input longint n, input longint d);
        if (d > 0) begin
            return (n >= 0) && (n <= d);
        end
        return (n <= 0) && (n >= d);
    endfunction

    // Exact parametric test of segment A->B against edge P->Q; parallel edges never hit.
    function automatic bit edge_crossed(input longint ax, input longint ay,
                                        input longint bx, input longint by,
                                        input longint px, input longint py,
                                        input longint qx, input longint qy);
        longint ex;
        longint ey;
        longint sgx;
        longint sgy;
        longint ox;
        longint oy;
        longint den;
        longint num_edge;
        longint num_seg;
        ex       = qx - px;
        ey       = qy - py;
        sgx      = bx - ax;
        sgy      = by - ay;
        ox       = ax - px;
        oy       = ay - py;
        den      = ey * sgx - ex * sgy;
        num_edge = ex * oy - ey * ox;
        num_seg  = sgx * oy - sgy * ox;
        if (den == 0) begin
            return 1'b0;
        end
        return param_in_unit(num_edge, den) && param_in_unit(num_seg, den);
    endfunction

    // Places the box and tests the four edges: left, right, top, bottom.
    function automatic bit segment_crosses_box(input logic [IN_W-1:0] query);
        longint f[12];
        longint base_x;
        longint base_y;
        longint x0;
        longint y0;
        longint x1;
        longint y1;
        for (int k = 0; k < 12; k++) begin
            f[k] = $signed(query[CW*k +: CW]);
        end
        base_x = f[4] - f[6];
        base_y = f[5] - f[7];
        x0 = base_x + f[8];
        y0 = base_y + f[9];
        x1 = base_x + f[10];
        y1 = base_y + f[11];
        return edge_crossed(f[0], f[1], f[2], f[3], x0, y0, x0, y1) ||
               edge_crossed(f[0], f[1], f[2], f[3], x1, y0, x1, y1) ||
               edge_crossed(f[0], f[1], f[2], f[3], x0, y0, x1, y0) ||
               edge_crossed(f[0], f[1], f[2], f[3], x0, y1, x1, y1);
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_hits       = 0;
    end

    // Results are matched before new queries are queued, so a result can never
    // pair with a query accepted on the same edge.
    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                if (hit_expected_q.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("unexpected result: hit=%0b with no query waiting",
                                 i_m_tdata[0]);
                    end
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = hit_expected_q.pop_front();
                    o_checked <= o_checked + 1;
                    if (i_m_tdata[0]) begin
                        o_hits <= o_hits + 1;
                    end
                    if (i_m_tdata[0] !== want) begin
                        if (o_fail_count < 10) begin
                            $display("result %0d: hit expected %0b, got %0b",
                                     o_checked, want, i_m_tdata[0]);
                        end
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                hit_expected_q.push_back(segment_crosses_box(i_s_tdata));
            end
            o_pending <= hit_expected_q.size();
        end
    end

endmodule

// File: tb/segment_box_intersect_tb.sv
// Testbench top: clock, reset, query stimulus, output back-pressure and the verdict.
module segment_box_intersect_tb;
    import sbi_pkg::*;

    localparam int N_RANDOM    = 1080;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AT     = 300;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    logic [IN_W-1:0]  i_s_axis_tdata;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    logic [OUT_W-1:0] o_m_axis_tdata;

    int fail_count;
    int pending;
    int checked;
    int hits;

    int  queries_accepted = 0;
    int  directed_count   = 0;
    bit  idle_on          = 1'b1;
    bit  hold_done        = 1'b0;
    int  cycle_count      = 0;

    segment_box_intersect u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    segment_box_intersect_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_hits       (hits)
    );

    // Clock with a period of two units.
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog on the total run length.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", cycle_count);
        $display("CHECK FAILED");
        $finish;
    end

    // Uniform value in [-lim, lim].
    function automatic int spread(input int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // Offers one query, with an optional idle burst first, and waits until it is taken.
    task automatic offer_query(input int f[12]);
        logic [IN_W-1:0] word;
        word = '0;
        for (int k = 0; k < 12; k++) begin
            word[CW*k +: CW] = f[k][CW-1:0];
        end
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= word;
        do begin
            @(posedge i_clk);
        end while (!o_s_axis_tready);
        queries_accepted++;
        @(negedge i_clk);
    endtask

    // Random query: mostly a box placed near the segment, sometimes raw or extreme fields.
    task automatic offer_random_query();
        int f[12];
        int span;
        int x0;
        int y0;
        int w;
        int h;
        int extremes[4];
        extremes = '{-32768, 32767, 0, -1};
        case ($urandom_range(0, 7))
            0: begin
                for (int k = 0; k < 12; k++) f[k] = $urandom();
            end
            1: begin
                for (int k = 0; k < 12; k++) f[k] = extremes[$urandom_range(0, 3)];
            end
            default: begin
                span = ($urandom_range(0, 2) == 0) ? 12 : 8000;
                for (int k = 4; k < 8; k++) f[k] = spread(span);
                x0 = spread(span);
                y0 = spread(span);
                w  = ($urandom_range(0, 7) == 0) ? 0 : spread(span);
                h  = ($urandom_range(0, 7) == 0) ? 0 : spread(span);
                f[8]  = x0 - (f[4] - f[6]);
                f[10] = x0 + w - (f[4] - f[6]);
                f[9]  = y0 - (f[5] - f[7]);
                f[11] = y0 + h - (f[5] - f[7]);
                f[0] = x0 + spread(span);
                f[1] = y0 + spread(span);
                f[2] = x0 + spread(span);
                f[3] = y0 + spread(span);
                // Push some segments onto box lines, along an axis, or to a single point.
                case ($urandom_range(0, 7))
                    0: f[0] = x0;
                    1: f[3] = y0 + h;
                    2: f[3] = f[1];
                    3: f[2] = f[0];
                    4: begin
                        f[2] = f[0];
                        f[3] = f[1];
                    end
                    default: ;
                endcase
            end
        endcase
        offer_query(f);
    endtask

    // Output back-pressure: random stall bursts and one long hold-off.
    initial begin
        int stall_left;
        stall_left = 0;
        i_m_axis_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready <= 1'b0;
            end else if (!hold_done && queries_accepted >= HOLD_AT) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                i_m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 6);
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    // Reset, directed queries, random queries, drain and verdict.
    initial begin
        int directed[][12];
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Fields: ax, ay, bx, by, pos x/y, org x/y, box left, top, right, bottom.
        directed = '{
            // Plain crossing of a box at the origin.
            '{-10, 5, 30, 5, 0, 0, 0, 0, 0, 0, 20, 10},
            // Segment wholly inside the box touches no edge.
            '{2, 2, 8, 8, 0, 0, 0, 0, 0, 0, 10, 10},
            // Far away.
            '{100, 100, 200, 200, 0, 0, 0, 0, 0, 0, 10, 10},
            // Endpoint lands exactly on the left edge.
            '{-5, 5, 0, 5, 0, 0, 0, 0, 0, 0, 10, 10},
            // Endpoint lands exactly on a corner.
            '{-5, -5, 0, 0, 0, 0, 0, 0, 0, 0, 10, 10},
            // Collinear with the top edge, inside its span.
            '{2, 0, 8, 0, 0, 0, 0, 0, 0, 0, 10, 10},
            // Collinear with the top edge, running past the corner.
            '{-5, 0, 15, 0, 0, 0, 0, 0, 0, 0, 10, 10},
            // Zero-width box: only the vertical edges can be hit.
            '{0, 5, 10, 5, 0, 0, 0, 0, 5, 0, 5, 10},
            // Box shrunk to a point: every edge is degenerate.
            '{0, 0, 10, 10, 0, 0, 0, 0, 5, 5, 5, 5},
            // Inverted box, left beyond right and top below bottom.
            '{10, -5, 10, 25, 0, 0, 0, 0, 20, 20, 0, 0},
            // Zero-length segment sitting on an edge.
            '{0, 5, 0, 5, 0, 0, 0, 0, 0, 0, 10, 10},
            // Every field at its minimum.
            '{-32768, -32768, -32768, -32768, -32768, -32768,
              -32768, -32768, -32768, -32768, -32768, -32768},
            // Every field at its maximum.
            '{32767, 32767, 32767, 32767, 32767, 32767,
              32767, 32767, 32767, 32767, 32767, 32767},
            // Widest placement to the positive side, corner touch.
            '{-32768, -32768, 32767, 32767, 32767, 32767, -32768, -32768,
              -32768, -32768, 32767, 32767},
            // Widest placement to the negative side.
            '{-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767,
              32767, 32767, -32768, -32768},
            // Alternating bit patterns.
            '{21845, -21846, -21846, 21845, 21845, -21846,
              -21846, 21845, 21845, -21846, -21846, 21845},
            '{-21846, 21845, 21845, -21846, -21846, 21845,
              21845, -21846, -21846, 21845, 21845, -21846},
            // Box moved by position and origin, segment through it.
            '{0, 150, 100, 150, 100, 200, 50, 50, -10, -10, 10, 10},
            // Same box, segment passes on its top side, clear of it.
            '{0, 0, 100, 0, 100, 200, 50, 50, -10, -10, 10, 10},
            // Vertical segment across top and bottom edges.
            '{5, -20, 5, 30, 0, 0, 0, 0, 0, 0, 10, 10},
            // Stops one short of the left edge.
            '{-5, 5, -1, 5, 0, 0, 0, 0, 0, 0, 10, 10}
        };
        foreach (directed[i]) begin
            offer_query(directed[i]);
        end
        directed_count = directed.size();

        // Random part; idling is switched per stretch and stays off at the end.
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 64 == 0) begin
                idle_on = (i < N_RANDOM - 150) && ($urandom_range(0, 3) != 0);
            end
            offer_random_query();
        end
        i_s_axis_tvalid <= 1'b0;

        // Drain the pipeline, then keep watching for stray output.
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);

        $display("Sent %0d segment-box queries (%0d directed), checked %0d results, %0d hits.",
                 queries_accepted, directed_count, checked, hits);
        $display("Output held off for %0d cycles once; idle bursts on both sides.",
                 HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
